// File: design/lpg_pkg.sv
// Shared types and constants for the line point generator.
// No dependencies; every other design file imports this package.
package lpg_pkg;

  localparam int COORD_W    = 6;
  localparam int SIZE_W     = 7;
  localparam int INK_W      = 8;
  localparam int IDX_W      = 2;
  localparam int CANVAS_MAX = 64;
  localparam int DEPTH      = 2;

  localparam logic [INK_W-1:0]  INK_RESET  = INK_W'(42);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(CANVAS_MAX);

  localparam logic [IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_INK_CHAR      = 2'd2;

  // One classified line: start point, absolute spans, directions, step count.
  typedef struct packed {
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] adx;
    logic [COORD_W-1:0] ady;
    logic               negx;
    logic               negy;
    logic [COORD_W-1:0] n;
  } line_desc_t;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [INK_W-1:0]  ink;
  } cfg_t;

endpackage

// File: design/lpg_front.sv
// Front end: turns a line command into spans, directions and step count.
// Depends on lpg_pkg.
module lpg_front (
  input  logic [lpg_pkg::COORD_W-1:0] start_x,
  input  logic [lpg_pkg::COORD_W-1:0] start_y,
  input  logic [lpg_pkg::COORD_W-1:0] end_x,
  input  logic [lpg_pkg::COORD_W-1:0] end_y,
  output lpg_pkg::line_desc_t         desc
);
  import lpg_pkg::*;

  logic               negx;
  logic               negy;
  logic [COORD_W-1:0] adx;
  logic [COORD_W-1:0] ady;

  assign negx = end_x < start_x;
  assign negy = end_y < start_y;
  assign adx  = negx ? (start_x - end_x) : (end_x - start_x);
  assign ady  = negy ? (start_y - end_y) : (end_y - start_y);

  always_comb begin
    desc.sx   = start_x;
    desc.sy   = start_y;
    desc.adx  = adx;
    desc.ady  = ady;
    desc.negx = negx;
    desc.negy = negy;
    desc.n    = (adx > ady) ? adx : ady;
  end
endmodule

// File: design/lpg_queue.sv
// Two-entry queue of classified lines between front and back end.
// Depends on lpg_pkg.
module lpg_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  lpg_pkg::line_desc_t wr_desc,
  output logic                full,
  input  logic                rd_en,
  output lpg_pkg::line_desc_t rd_desc,
  output logic                empty
);
  import lpg_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  line_desc_t         slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  assign full    = count == (PTR_W+1)'(DEPTH);
  assign empty   = count == '0;
  assign rd_desc = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_desc;
    end
  end
endmodule

// File: design/lpg_back.sv
// Back end: steps quotients incrementally; one point per cycle when slot is free.
// Depends on lpg_pkg.
module lpg_back (
  input  logic                         clk,
  input  logic                         rst,
  input  lpg_pkg::cfg_t                cfg,
  input  lpg_pkg::line_desc_t          q_desc,
  input  logic                         q_empty,
  output logic                         q_pop,
  output logic                         empty,
  input  logic                         pop,
  output logic [lpg_pkg::COORD_W-1:0]  point_x,
  output logic [lpg_pkg::COORD_W-1:0]  point_y,
  output logic                         inside_res,
  output logic [lpg_pkg::INK_W-1:0]    ink,
  output logic                         last_point
);
  import lpg_pkg::*;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t             state;
  line_desc_t         cur;
  logic [COORD_W-1:0] step;
  logic [COORD_W-1:0] qx;
  logic [COORD_W-1:0] qy;
  logic [COORD_W:0]   rx;
  logic [COORD_W:0]   ry;
  logic               out_valid;

  logic               slot_free;
  logic               is_last;
  logic [COORD_W:0]   rx_sum;
  logic [COORD_W:0]   ry_sum;
  logic               rx_wrap;
  logic               ry_wrap;
  logic [COORD_W-1:0] x;
  logic [COORD_W-1:0] y;

  assign slot_free = !out_valid || pop;
  assign is_last   = step == cur.n;
  assign rx_sum    = rx + {1'b0, cur.adx};
  assign ry_sum    = ry + {1'b0, cur.ady};
  assign rx_wrap   = rx_sum >= {1'b0, cur.n};
  assign ry_wrap   = ry_sum >= {1'b0, cur.n};
  assign x         = cur.negx ? (cur.sx - qx) : (cur.sx + qx);
  assign y         = cur.negy ? (cur.sy - qy) : (cur.sy + qy);
  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          // drop the held point once it is transferred
          if (pop) begin
            out_valid <= 1'b0;
          end
          if (!q_empty) begin
            cur   <= q_desc;
            step  <= '0;
            qx    <= '0;
            qy    <= '0;
            rx    <= '0;
            ry    <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            point_x    <= x;
            point_y    <= y;
            inside_res <= ({1'b0, x} < cfg.width) && ({1'b0, y} < cfg.height);
            ink        <= cfg.ink;
            last_point <= is_last;
            if (is_last) begin
              state <= ST_IDLE;
            end else begin
              // advance i: remainder of i*span/n never exceeds one wrap per step
              step <= step + 1'b1;
              rx   <= rx_wrap ? rx_sum - {1'b0, cur.n} : rx_sum;
              ry   <= ry_wrap ? ry_sum - {1'b0, cur.n} : ry_sum;
              qx   <= qx + COORD_W'(rx_wrap);
              qy   <= qy + COORD_W'(ry_wrap);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// File: design/line_point_generator.sv
// Line point generator: emits the n+1 points of a line, n = max(|dx|, |dy|).
// A command passes through the queue and the back end's load state before its
// first point is registered. The stepper loads a line, then emits one point per
// cycle unless a point waits for pop; a two-entry queue decouples the input.
// Reset (rst, synchronous, active high) empties the queue and output register
// and sets canvas width and height to 64 and ink to '*'.
module line_point_generator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [lpg_pkg::COORD_W-1:0]  start_x,
  input  logic [lpg_pkg::COORD_W-1:0]  start_y,
  input  logic [lpg_pkg::COORD_W-1:0]  end_x,
  input  logic [lpg_pkg::COORD_W-1:0]  end_y,
  output logic                         empty,
  input  logic                         pop,
  output logic [lpg_pkg::COORD_W-1:0]  point_x,
  output logic [lpg_pkg::COORD_W-1:0]  point_y,
  output logic                         inside_res,
  output logic [lpg_pkg::INK_W-1:0]    ink,
  output logic                         last_point,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lpg_pkg::IDX_W-1:0]    cfg_index,
  input  logic [lpg_pkg::INK_W-1:0]    cfg_data
);
  import lpg_pkg::*;

  cfg_t       cfg;
  line_desc_t front_desc;
  line_desc_t q_desc;
  logic       q_empty;
  logic       q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= SIZE_RESET;
      cfg.height <= SIZE_RESET;
      cfg.ink    <= INK_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CANVAS_WIDTH:  cfg.width  <= cfg_data[SIZE_W-1:0];
        REG_CANVAS_HEIGHT: cfg.height <= cfg_data[SIZE_W-1:0];
        REG_INK_CHAR:      cfg.ink    <= cfg_data;
        default:           cfg        <= cfg;  // drop writes beyond the map
      endcase
    end
  end

  lpg_front u_front (
    .start_x (start_x),
    .start_y (start_y),
    .end_x   (end_x),
    .end_y   (end_y),
    .desc    (front_desc)
  );

  lpg_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !full),
    .wr_desc (front_desc),
    .full    (full),
    .rd_en   (q_pop),
    .rd_desc (q_desc),
    .empty   (q_empty)
  );

  lpg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_desc     (q_desc),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .point_x    (point_x),
    .point_y    (point_y),
    .inside_res (inside_res),
    .ink        (ink),
    .last_point (last_point)
  );
endmodule

// File: verif/line_point_checker.sv
`timescale 1ns / 100ps
// Point checker for the line point generator: watches the command, point and
// register channels, plots every accepted line itself and compares each point.
// Depends on lpg_pkg for widths, register indexes and reset values.
module line_point_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic                         full,
  input  logic [lpg_pkg::COORD_W-1:0]  start_x,
  input  logic [lpg_pkg::COORD_W-1:0]  start_y,
  input  logic [lpg_pkg::COORD_W-1:0]  end_x,
  input  logic [lpg_pkg::COORD_W-1:0]  end_y,
  input  logic                         empty,
  input  logic                         pop,
  input  logic [lpg_pkg::COORD_W-1:0]  point_x,
  input  logic [lpg_pkg::COORD_W-1:0]  point_y,
  input  logic                         inside_res,
  input  logic [lpg_pkg::INK_W-1:0]    ink,
  input  logic                         last_point,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [lpg_pkg::IDX_W-1:0]    cfg_index,
  input  logic [lpg_pkg::INK_W-1:0]    cfg_data,
  output int                           fail_count,
  output int                           pending
);
  import lpg_pkg::*;

  typedef struct {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic               in_canvas;
    logic [INK_W-1:0]   ink;
    logic               last;
  } point_t;

  point_t expected_points[$];
  cfg_t   canvas_cfg;
  int     errors = 0;

  function automatic int clip_size(logic [SIZE_W-1:0] size);
    return (int'(size) > CANVAS_MAX) ? CANVAS_MAX : int'(size);
  endfunction

  // Queue the n+1 points of one line, n = max(|dx|, |dy|).
  function automatic void plot_line(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                                    logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey);
    int     dx, dy, adx, ady, n, x, y, w, h, i;
    point_t p;
    dx  = int'(ex) - int'(sx);
    dy  = int'(ey) - int'(sy);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    n   = (adx > ady) ? adx : ady;
    w   = clip_size(canvas_cfg.width);
    h   = clip_size(canvas_cfg.height);
    for (i = 0; i <= n; i++) begin
      if (n == 0) begin
        x = int'(sx);
        y = int'(sy);
      end else begin
        // int division truncates toward zero
        x = int'(sx) + (i * dx) / n;
        y = int'(sy) + (i * dy) / n;
      end
      p.px        = COORD_W'(x);
      p.py        = COORD_W'(y);
      p.in_canvas = (x >= 0) && (y >= 0) && (x < w) && (y < h);
      p.ink       = canvas_cfg.ink;
      p.last      = (i == n);
      expected_points.insert(expected_points.size(), p);
    end
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    point_t want;
    if (rst) begin
      canvas_cfg = '{width: SIZE_RESET, height: SIZE_RESET, ink: INK_RESET};
      expected_points.delete();
    end else begin
      // take the point first so a command landing on the same edge cannot match it
      if (pop && !empty) begin
        if (expected_points.size() == 0) begin
          $error("point (%0d, %0d) transferred with no point expected", point_x, point_y);
          errors++;
        end else begin
          want = expected_points[0];
          expected_points.delete(0);
          check_field("point_x", want.px, point_x);
          check_field("point_y", want.py, point_y);
          check_field("inside_res", want.in_canvas, inside_res);
          check_field("ink", want.ink, ink);
          check_field("last_point", want.last, last_point);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CANVAS_WIDTH:  canvas_cfg.width  = cfg_data[SIZE_W-1:0];
          REG_CANVAS_HEIGHT: canvas_cfg.height = cfg_data[SIZE_W-1:0];
          REG_INK_CHAR:      canvas_cfg.ink    = cfg_data;
          default: ;
        endcase
      end
      if (push && !full)
        plot_line(start_x, start_y, end_x, end_y);
    end
    fail_count <= errors;
    pending    <= expected_points.size();
  end

endmodule

// File: verif/line_point_generator_tb.sv
`timescale 1ns / 100ps
// Testbench top for the line point generator: drives line commands and
// register writes with random idling, and reports the verdict.
// Depends on lpg_pkg, line_point_generator and line_point_checker.
module line_point_generator_tb;
  import lpg_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PCT      = 37;
  localparam int RAND_PHASES   = 5;
  localparam int PHASE_LINES   = 62;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               push       = 1'b0;
  logic [COORD_W-1:0] start_x    = '0;
  logic [COORD_W-1:0] start_y    = '0;
  logic [COORD_W-1:0] end_x      = '0;
  logic [COORD_W-1:0] end_y      = '0;
  logic               pop        = 1'b0;
  logic               cfg_valid  = 1'b0;
  logic [IDX_W-1:0]   cfg_index  = '0;
  logic [INK_W-1:0]   cfg_data   = '0;
  logic               full, empty, inside_res, last_point, cfg_ready;
  logic [COORD_W-1:0] point_x, point_y;
  logic [INK_W-1:0]   ink;
  bit                 steady     = 1'b0;
  int                 fail_count;
  int                 pending;

  always #5 clk = ~clk;

  line_point_generator dut (
    .clk, .rst, .push, .full, .start_x, .start_y, .end_x, .end_y,
    .empty, .pop, .point_x, .point_y, .inside_res, .ink, .last_point,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  line_point_checker u_point_check (
    .clk, .rst, .push, .full, .start_x, .start_y, .end_x, .end_y,
    .empty, .pop, .point_x, .point_y, .inside_res, .ink, .last_point,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending
  );

  always @(posedge clk)
    pop <= steady || ($urandom_range(99) >= IDLE_PCT);

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [INK_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_line(int sx, int sy, int ex, int ey);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    start_x <= COORD_W'(sx);
    start_y <= COORD_W'(sy);
    end_x   <= COORD_W'(ex);
    end_y   <= COORD_W'(ey);
    do @(posedge clk); while (full);
  endtask

  // Hold off commands until every expected point has been transferred.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : (v > 63) ? 63 : v;
  endfunction

  function automatic logic [INK_W-1:0] pick_size();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd64;
      3: return 8'd127;
      4: return 8'd255;  // top bit is dropped by the register
      default: return INK_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random_line();
    int sx, sy, ex, ey, d;
    sx = $urandom_range(63);
    sy = $urandom_range(63);
    ex = $urandom_range(63);
    ey = $urandom_range(63);
    d  = $urandom_range(63);
    case ($urandom_range(9))
      6, 7: begin
        // short line around the start point
        ex = clamp_coord(sx + int'($urandom_range(8)) - 4);
        ey = clamp_coord(sy + int'($urandom_range(8)) - 4);
      end
      8: begin
        if ($urandom_range(1)) ex = sx;
        else ey = sy;
      end
      9: begin
        ex = clamp_coord(sx + d);
        ey = clamp_coord(sy - d);
      end
      default: ;
    endcase
    send_line(sx, sy, ex, ey);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: extremes, degenerate lines, axis and steep lines
    send_line(0, 0, 63, 63);
    send_line(63, 63, 0, 0);
    send_line(0, 63, 63, 0);
    send_line(5, 9, 5, 9);
    send_line(63, 63, 63, 63);
    send_line(0, 0, 0, 0);
    send_line(0, 17, 63, 17);
    send_line(40, 63, 40, 0);
    send_line(10, 20, 3, 61);
    send_line(62, 1, 0, 30);
    send_line(21, 42, 42, 21);
    drain();

    // zero width marks everything outside; oversized height is limited
    write_reg(REG_CANVAS_WIDTH, 8'd0);
    write_reg(REG_CANVAS_HEIGHT, 8'd255);
    write_reg(REG_INK_CHAR, 8'd0);
    send_line(0, 0, 63, 63);
    send_line(7, 7, 7, 7);
    drain();

    write_reg(REG_CANVAS_WIDTH, 8'd127);
    write_reg(REG_CANVAS_HEIGHT, 8'd0);
    write_reg(REG_INK_CHAR, 8'd255);
    send_line(63, 0, 0, 63);
    send_line(30, 30, 33, 31);
    drain();

    write_reg(REG_CANVAS_WIDTH, 8'd1);
    write_reg(REG_CANVAS_HEIGHT, 8'd1);
    write_reg(REG_INK_CHAR, 8'h5A);
    send_line(0, 0, 2, 1);
    send_line(1, 0, 0, 1);
    send_line(0, 0, 0, 0);
    drain();

    // a write to the unused index must leave every register alone
    write_reg(REG_CANVAS_WIDTH, 8'd33);
    write_reg(REG_CANVAS_HEIGHT, 8'd20);
    write_reg(REG_INK_CHAR, 8'hA5);
    write_reg(REG_SPARE, 8'h11);
    send_line(0, 0, 63, 40);
    send_line(50, 10, 10, 50);
    drain();

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      write_reg(REG_CANVAS_WIDTH, pick_size());
      write_reg(REG_CANVAS_HEIGHT, pick_size());
      write_reg(REG_INK_CHAR, INK_W'($urandom_range(255)));
      if ($urandom_range(1))
        write_reg(REG_SPARE, INK_W'($urandom_range(255)));
      steady = (phase == 2);
      for (int k = 0; k < PHASE_LINES; k++) begin
        if (phase == 0 && k == PHASE_LINES / 2)
          drain();
        send_random_line();
      end
      drain();
    end

    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
